@@ hdl/lpf_pkg.sv @@
// Shared types and constants for the length-prefixed packet FIFO framer.
package lpf_pkg;

  localparam int BYTE_W = 8;
  localparam int PIU_W = 5;
  localparam logic [PIU_W-1:0] PIU_RESET = 5'd16;

  // Push status codes.
  localparam logic [1:0] ST_BYTE_TAKEN = 2'd0;
  localparam logic [1:0] ST_QUEUED     = 2'd1;
  localparam logic [1:0] ST_DROP_FULL  = 2'd2;
  localparam logic [1:0] ST_DROP_SIZE  = 2'd3;

  // Item modes.
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FETCH
  } state_t;

  typedef struct packed {
    logic capture;
    logic do_push;
    logic read_issue;
    logic read_finish;
    logic read_empty;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_read;
    logic read_ready;
  } dp_status_t;

endpackage

@@ hdl/length_prefixed_packet_fifo_framer_top.sv @@
// Top level of the length-prefixed packet FIFO framer.
//
// A transaction is accepted on a rising edge with start high and busy low.
// mode 0 pushes one packet byte (push_byte, push_last on the final byte);
// mode 1 reads the next serialized byte: first the length prefix
// (size + HEADER_LEN), then every stored header and data byte, after which
// the packet is popped. A read of an empty queue answers zeros.
// Each result sits on the result ports for one cycle with done high; the
// receiver cannot stall, so results are never held.
// Sequence: acceptance captures the transaction (S_IDLE), S_EXEC performs a
// push or an empty-queue read, and a read of a non-empty queue adds S_FETCH for
// the registered packet store read; done is registered after the last of these
// states. busy falls as done rises, so the next transaction can be accepted on
// the edge that takes the result, with at most one transaction in flight.
// The cfg_write_en / cfg_write_data port sets packets_in_use, the slot
// limit, which applies as min(packets_in_use, QUEUE_DEPTH); write it only
// while idle. Reset (rst, synchronous) empties the queue and sets the limit
// to 16; the packet store is not cleared and needs no clearing pass.
module length_prefixed_packet_fifo_framer_top #(
  parameter int QUEUE_DEPTH = 16,
  parameter int MAX_DATA = 64,
  parameter int HEADER_LEN = 4,
  parameter int SIZE_OFFSET = 0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [7:0]  push_byte,
  input  logic        push_last,
  input  logic        cfg_write_en,
  input  logic [4:0]  cfg_write_data,
  output logic        done,
  output logic [7:0]  read_byte,
  output logic        read_valid,
  output logic        read_is_length,
  output logic        read_last,
  output logic [1:0]  push_status
);

  lpf_pkg::ctrl_cmd_t  cmd;
  lpf_pkg::dp_status_t status;

  lpf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .status(status),
    .cmd   (cmd),
    .busy  (busy)
  );

  lpf_dp #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .MAX_DATA   (MAX_DATA),
    .HEADER_LEN (HEADER_LEN),
    .SIZE_OFFSET(SIZE_OFFSET)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .mode          (mode),
    .push_byte     (push_byte),
    .push_last     (push_last),
    .done          (done),
    .read_byte     (read_byte),
    .read_valid    (read_valid),
    .read_is_length(read_is_length),
    .read_last     (read_last),
    .push_status   (push_status)
  );

endmodule

@@ hdl/lpf_ram.sv @@
// Generic single-port RAM with registered read.
module lpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1088
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ hdl/lpf_ctrl.sv @@
// Controller state machine that sequences push and read transactions.
module lpf_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  lpf_pkg::dp_status_t   status,
  output lpf_pkg::ctrl_cmd_t    cmd,
  output logic                  busy
);

  lpf_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lpf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = 1'b1;
    case (state)
      lpf_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          state_next = lpf_pkg::S_EXEC;
        end
      end
      lpf_pkg::S_EXEC: begin
        if (!status.is_read) begin
          cmd.do_push = 1'b1;
          state_next = lpf_pkg::S_IDLE;
        end else if (status.read_ready) begin
          cmd.read_issue = 1'b1;
          state_next = lpf_pkg::S_FETCH;
        end else begin
          cmd.read_empty = 1'b1;
          state_next = lpf_pkg::S_IDLE;
        end
      end
      lpf_pkg::S_FETCH: begin
        cmd.read_finish = 1'b1;
        state_next = lpf_pkg::S_IDLE;
      end
      default: begin
        state_next = lpf_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/lpf_dp.sv @@
// Datapath: packet store, queue pointers, push and read bookkeeping, result registers.
module lpf_dp #(
  parameter int QUEUE_DEPTH = 16,
  parameter int MAX_DATA = 64,
  parameter int HEADER_LEN = 4,
  parameter int SIZE_OFFSET = 0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  lpf_pkg::ctrl_cmd_t         cmd,
  output lpf_pkg::dp_status_t        status,
  input  logic                       cfg_write_en,
  input  logic [lpf_pkg::PIU_W-1:0]  cfg_write_data,
  input  logic                       mode,
  input  logic [lpf_pkg::BYTE_W-1:0] push_byte,
  input  logic                       push_last,
  output logic                       done,
  output logic [lpf_pkg::BYTE_W-1:0] read_byte,
  output logic                       read_valid,
  output logic                       read_is_length,
  output logic                       read_last,
  output logic [1:0]                 push_status
);

  localparam int SLOT_LEN = HEADER_LEN + MAX_DATA;
  localparam int STORE_LEN = QUEUE_DEPTH * SLOT_LEN;
  localparam int AW = $clog2(STORE_LEN);
  localparam int SUMW = ((AW > 8) ? AW : 8) + 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  // Captured transaction.
  logic                       mode_q;
  logic [lpf_pkg::BYTE_W-1:0] byte_q;
  logic                       last_q;

  logic [lpf_pkg::PIU_W-1:0] packets_in_use;
  logic [AW-1:0]   head_base;
  logic [AW-1:0]   tail_base;
  logic [CNTW-1:0] packet_count;
  logic            reading_active;
  logic [7:0]      read_offset;
  logic [7:0]      bytes_remaining;
  logic [7:0]      push_offset;
  logic            push_dropping;
  logic [7:0]      size_reg;

  logic [7:0]      limit;
  logic            full;
  logic [7:0]      size_now;
  logic [7:0]      off_inc;
  logic            drop_now;
  logic [1:0]      last_status;
  logic [AW-1:0]   head_adv;
  logic [AW-1:0]   tail_adv;
  logic [SUMW-1:0] head_sum;
  logic [SUMW-1:0] tail_sum;

  logic            ram_we;
  logic            ram_re;
  logic [AW-1:0]   ram_addr;
  logic [7:0]      ram_rdata;
  logic [7:0]      len_byte;

  lpf_ram #(
    .WIDTH(lpf_pkg::BYTE_W),
    .DEPTH(STORE_LEN)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .re   (ram_re),
    .addr (ram_addr),
    .wdata(byte_q),
    .rdata(ram_rdata)
  );

  assign status.is_read = (mode_q == lpf_pkg::MODE_READ);
  assign status.read_ready = reading_active || (packet_count != '0);

  assign limit = (8'(packets_in_use) < 8'(QUEUE_DEPTH)) ? 8'(packets_in_use)
                                                        : 8'(QUEUE_DEPTH);
  assign full = (8'(packet_count) >= limit);
  assign drop_now = push_dropping || full;
  assign size_now = (push_offset == 8'(SIZE_OFFSET)) ? byte_q : size_reg;
  assign off_inc = (push_offset == 8'd255) ? push_offset : push_offset + 8'd1;

  // Slot bases wrap back to zero after the last slot.
  assign head_sum = SUMW'(head_base) + SUMW'(SLOT_LEN);
  assign tail_sum = SUMW'(tail_base) + SUMW'(SLOT_LEN);
  assign head_adv = (head_sum == SUMW'(STORE_LEN)) ? '0 : head_sum[AW-1:0];
  assign tail_adv = (tail_sum == SUMW'(STORE_LEN)) ? '0 : tail_sum[AW-1:0];

  assign len_byte = ram_rdata + 8'(HEADER_LEN);

  always_comb begin
    if (drop_now) begin
      last_status = lpf_pkg::ST_DROP_FULL;
    end else if (off_inc <= 8'(SIZE_OFFSET) || off_inc < 8'(HEADER_LEN)) begin
      last_status = lpf_pkg::ST_DROP_SIZE;
    end else if (size_now > 8'(MAX_DATA) ||
                 9'(off_inc) < 9'(HEADER_LEN) + 9'(size_now)) begin
      last_status = lpf_pkg::ST_DROP_SIZE;
    end else begin
      last_status = lpf_pkg::ST_QUEUED;
    end
  end

  always_comb begin
    ram_we = 1'b0;
    ram_re = 1'b0;
    ram_addr = tail_base;
    if (cmd.do_push) begin
      ram_we = !full && (push_offset < 8'(SLOT_LEN));
      ram_addr = AW'(SUMW'(tail_base) + SUMW'(push_offset));
    end else if (cmd.read_issue) begin
      ram_re = 1'b1;
      if (reading_active) begin
        ram_addr = AW'(SUMW'(head_base) + SUMW'(read_offset));
      end else begin
        ram_addr = AW'(SUMW'(head_base) + SUMW'(SIZE_OFFSET));
      end
    end
  end

  // Captured inputs and result fields carry no reset.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q <= mode;
      byte_q <= push_byte;
      last_q <= push_last;
    end
    if (cmd.do_push && !full && push_offset == 8'(SIZE_OFFSET)) begin
      size_reg <= byte_q;
    end
    if (cmd.do_push) begin
      read_byte <= '0;
      read_valid <= 1'b0;
      read_is_length <= 1'b0;
      read_last <= 1'b0;
      push_status <= last_q ? last_status : lpf_pkg::ST_BYTE_TAKEN;
    end else if (cmd.read_empty) begin
      read_byte <= '0;
      read_valid <= 1'b0;
      read_is_length <= 1'b0;
      read_last <= 1'b0;
      push_status <= lpf_pkg::ST_BYTE_TAKEN;
    end else if (cmd.read_finish) begin
      read_valid <= 1'b1;
      push_status <= lpf_pkg::ST_BYTE_TAKEN;
      if (!reading_active) begin
        read_byte <= len_byte;
        read_is_length <= 1'b1;
        read_last <= 1'b0;
      end else begin
        read_byte <= ram_rdata;
        read_is_length <= 1'b0;
        read_last <= (bytes_remaining <= 8'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packets_in_use <= lpf_pkg::PIU_RESET;
      head_base <= '0;
      tail_base <= '0;
      packet_count <= '0;
      reading_active <= 1'b0;
      read_offset <= '0;
      bytes_remaining <= '0;
      push_offset <= '0;
      push_dropping <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= cmd.do_push || cmd.read_empty || cmd.read_finish;
      if (cfg_write_en) begin
        packets_in_use <= cfg_write_data;
      end
      if (cmd.do_push) begin
        if (last_q) begin
          push_offset <= '0;
          push_dropping <= 1'b0;
          if (last_status == lpf_pkg::ST_QUEUED) begin
            tail_base <= tail_adv;
            packet_count <= packet_count + CNTW'(1);
          end
        end else begin
          push_offset <= off_inc;
          push_dropping <= drop_now;
        end
      end else if (cmd.read_finish) begin
        if (!reading_active) begin
          bytes_remaining <= len_byte;
          read_offset <= '0;
          reading_active <= 1'b1;
        end else if (bytes_remaining <= 8'd1) begin
          // Final byte of the packet: pop it.
          bytes_remaining <= '0;
          read_offset <= '0;
          reading_active <= 1'b0;
          head_base <= head_adv;
          packet_count <= packet_count - CNTW'(1);
        end else begin
          bytes_remaining <= bytes_remaining - 8'd1;
          read_offset <= read_offset + 8'd1;
        end
      end
    end
  end

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the length-prefixed packet FIFO framer top level.
`timescale 1ns / 1ps

module tb_top;

  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_DATA = 64;
  localparam int HEADER_LEN = 4;
  localparam int SIZE_OFFSET = 0;
  localparam int SLOT_LEN = HEADER_LEN + MAX_DATA;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int DIRECTED_ROWS = 27;

  typedef struct packed {
    logic [7:0] rbyte;
    logic       valid;
    logic       is_len;
    logic       lst;
    logic [1:0] status;
  } framer_reply_t;

  typedef struct {
    logic          m;
    logic [7:0]    b;
    logic          l;
    bit            typed;
    framer_reply_t want;
  } stim_row_t;

  localparam framer_reply_t R_NONE = '0;
  localparam framer_reply_t R_QUEUED = '{8'd0, 1'b0, 1'b0, 1'b0, lpf_pkg::ST_QUEUED};
  localparam framer_reply_t R_DROP_SIZE = '{8'd0, 1'b0, 1'b0, 1'b0, lpf_pkg::ST_DROP_SIZE};

  logic       clk = 1'b0;
  logic       rst;
  logic       start;
  logic       busy;
  logic       mode;
  logic [7:0] push_byte;
  logic       push_last;
  logic       cfg_write_en;
  logic [4:0] cfg_write_data;
  logic       done;
  logic [7:0] read_byte;
  logic       read_valid;
  logic       read_is_length;
  logic       read_last;
  logic [1:0] push_status;

  // Expected replies, oldest first, one per accepted transaction.
  framer_reply_t replies_due[$];

  // Predictor copy of the framer state and its slot limit.
  logic [7:0] slot_bytes [QUEUE_DEPTH*SLOT_LEN];
  int         head_idx, tail_idx, queued_pkts, rd_off, push_off;
  logic [7:0] rd_left;
  logic       rd_active, push_drop;
  logic [4:0] slot_limit_cfg;

  int  err_count, n_checked, items_sent, cycle_count;
  int  n_queued, n_drop_full, n_drop_size, n_serialized;
  bit  no_gaps;
  stim_row_t directed_rows [DIRECTED_ROWS];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  length_prefixed_packet_fifo_framer_top #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .MAX_DATA(MAX_DATA),
    .HEADER_LEN(HEADER_LEN),
    .SIZE_OFFSET(SIZE_OFFSET)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .push_byte(push_byte),
    .push_last(push_last),
    .cfg_write_en(cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .done(done),
    .read_byte(read_byte),
    .read_valid(read_valid),
    .read_is_length(read_is_length),
    .read_last(read_last),
    .push_status(push_status)
  );

  // Advances the predicted framer state by one transaction and returns its reply.
  task automatic compute_framer_reply(input logic m, input logic [7:0] b, input logic lst,
                                      output framer_reply_t r);
    int lim, cnt, sz;
    r = '0;
    lim = (slot_limit_cfg < QUEUE_DEPTH) ? int'(slot_limit_cfg) : QUEUE_DEPTH;
    if (m == lpf_pkg::MODE_PUSH) begin
      if (queued_pkts >= lim) begin
        push_drop = 1'b1;
      end else if (push_off < SLOT_LEN) begin
        slot_bytes[tail_idx*SLOT_LEN + push_off] = b;
      end
      if (push_off < 255) push_off++;
      if (lst) begin
        cnt = push_off;
        if (push_drop || queued_pkts >= lim) begin
          r.status = lpf_pkg::ST_DROP_FULL;
        end else if (cnt <= SIZE_OFFSET || cnt < HEADER_LEN) begin
          r.status = lpf_pkg::ST_DROP_SIZE;
        end else begin
          sz = int'(slot_bytes[tail_idx*SLOT_LEN + SIZE_OFFSET]);
          if (sz > MAX_DATA || cnt < HEADER_LEN + sz) begin
            r.status = lpf_pkg::ST_DROP_SIZE;
          end else begin
            r.status = lpf_pkg::ST_QUEUED;
            tail_idx = (tail_idx + 1) % QUEUE_DEPTH;
            queued_pkts++;
          end
        end
        push_off = 0;
        push_drop = 1'b0;
      end
    end else if (!rd_active) begin
      if (queued_pkts != 0) begin
        rd_left = slot_bytes[head_idx*SLOT_LEN + SIZE_OFFSET] + 8'(HEADER_LEN);
        rd_off = 0;
        rd_active = 1'b1;
        r.rbyte = rd_left;
        r.valid = 1'b1;
        r.is_len = 1'b1;
        if (rd_left == 0) begin
          rd_active = 1'b0;
          r.lst = 1'b1;
          head_idx = (head_idx + 1) % QUEUE_DEPTH;
          queued_pkts--;
        end
      end
    end else begin
      r.rbyte = slot_bytes[head_idx*SLOT_LEN + rd_off];
      r.valid = 1'b1;
      rd_off++;
      if (rd_left != 0) rd_left--;
      if (rd_left == 0) begin
        r.lst = 1'b1;
        rd_active = 1'b0;
        rd_off = 0;
        head_idx = (head_idx + 1) % QUEUE_DEPTH;
        if (queued_pkts != 0) queued_pkts--;
      end
    end
  endtask

  // Drives one transaction, waits for it to be accepted, then idles at random.
  task automatic send_item(input logic m, input logic [7:0] b, input logic l,
                           input bit typed, input framer_reply_t want);
    framer_reply_t pr;
    int gap, pick;
    @(negedge clk);
    start <= 1'b1;
    mode <= m;
    push_byte <= b;
    push_last <= l;
    @(posedge clk);
    while (busy) @(posedge clk);
    compute_framer_reply(m, b, l, pr);
    replies_due.push_back(typed ? want : pr);
    items_sent++;
    case (pr.status)
      lpf_pkg::ST_QUEUED:    n_queued++;
      lpf_pkg::ST_DROP_FULL: n_drop_full++;
      lpf_pkg::ST_DROP_SIZE: n_drop_size++;
      default:               if (pr.valid) n_serialized++;
    endcase
    pick = $urandom_range(0, 99);
    if (no_gaps || pick < 60) gap = 0;
    else if (pick < 93) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      @(negedge clk) start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Holds the sender off until every outstanding transaction has replied.
  task automatic wait_drained();
    @(negedge clk) start <= 1'b0;
    while (replies_due.size() != 0 || busy) @(negedge clk);
  endtask

  task automatic push_packet(input int size_val, input int n_bytes);
    for (int i = 0; i < n_bytes; i++) begin
      send_item(lpf_pkg::MODE_PUSH, (i == SIZE_OFFSET) ? size_val[7:0] : 8'($urandom),
                i == n_bytes - 1, 1'b0, R_NONE);
    end
  endtask

  always @(posedge clk) begin : check_replies
    framer_reply_t want;
    if (!rst && done) begin
      if (replies_due.size() == 0) begin
        $error("result strobe with no transaction outstanding");
        err_count++;
      end else begin
        want = replies_due.pop_front();
        n_checked++;
        if (read_byte !== want.rbyte) begin
          $error("read_byte: expected %0d, got %0d", want.rbyte, read_byte);
          err_count++;
        end
        if (read_valid !== want.valid) begin
          $error("read_valid: expected %0d, got %0d", want.valid, read_valid);
          err_count++;
        end
        if (read_is_length !== want.is_len) begin
          $error("read_is_length: expected %0d, got %0d", want.is_len, read_is_length);
          err_count++;
        end
        if (read_last !== want.lst) begin
          $error("read_last: expected %0d, got %0d", want.lst, read_last);
          err_count++;
        end
        if (push_status !== want.status) begin
          $error("push_status: expected %0d, got %0d", want.status, push_status);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** length_prefixed_packet_fifo_framer_top: FAILED **");
      $finish;
    end
  end

  initial begin
    int r, push_pct, phase_start, kind, sz, n;
    logic [4:0] cfg;

    foreach (slot_bytes[i]) slot_bytes[i] = '0;
    head_idx = 0;
    tail_idx = 0;
    queued_pkts = 0;
    rd_off = 0;
    push_off = 0;
    rd_left = '0;
    rd_active = 1'b0;
    push_drop = 1'b0;
    slot_limit_cfg = lpf_pkg::PIU_RESET;
    err_count = 0;
    n_checked = 0;
    items_sent = 0;
    cycle_count = 0;
    n_queued = 0;
    n_drop_full = 0;
    n_drop_size = 0;
    n_serialized = 0;
    no_gaps = 1'b0;

    rst = 1'b1;
    start = 1'b0;
    mode = lpf_pkg::MODE_PUSH;
    push_byte = '0;
    push_last = 1'b0;
    cfg_write_en = 1'b0;
    cfg_write_data = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Empty read, a short packet, a minimal packet, an oversize one, a one-byte
    // data packet, then both packets read out and a read of the empty queue.
    directed_rows = '{
      '{lpf_pkg::MODE_READ, 8'hFF, 1'b1, 1'b1, R_NONE},
      '{lpf_pkg::MODE_PUSH, 8'h00, 1'b1, 1'b1, R_DROP_SIZE},
      '{lpf_pkg::MODE_PUSH, 8'h00, 1'b0, 1'b1, R_NONE},
      '{lpf_pkg::MODE_PUSH, 8'hFF, 1'b0, 1'b1, R_NONE},
      '{lpf_pkg::MODE_PUSH, 8'hAA, 1'b0, 1'b1, R_NONE},
      '{lpf_pkg::MODE_PUSH, 8'h55, 1'b1, 1'b1, R_QUEUED},
      '{lpf_pkg::MODE_PUSH, 8'(MAX_DATA + 1), 1'b0, 1'b1, R_NONE},
      '{lpf_pkg::MODE_PUSH, 8'h01, 1'b0, 1'b1, R_NONE},
      '{lpf_pkg::MODE_PUSH, 8'h02, 1'b0, 1'b1, R_NONE},
      '{lpf_pkg::MODE_PUSH, 8'h03, 1'b1, 1'b1, R_DROP_SIZE},
      '{lpf_pkg::MODE_PUSH, 8'h01, 1'b0, 1'b0, R_NONE},
      '{lpf_pkg::MODE_PUSH, 8'h12, 1'b0, 1'b0, R_NONE},
      '{lpf_pkg::MODE_PUSH, 8'h34, 1'b0, 1'b0, R_NONE},
      '{lpf_pkg::MODE_PUSH, 8'h56, 1'b0, 1'b0, R_NONE},
      '{lpf_pkg::MODE_PUSH, 8'hFF, 1'b1, 1'b0, R_NONE},
      '{lpf_pkg::MODE_READ, 8'h00, 1'b0, 1'b1,
        '{8'(HEADER_LEN), 1'b1, 1'b1, 1'b0, lpf_pkg::ST_BYTE_TAKEN}},
      '{lpf_pkg::MODE_READ, 8'hFF, 1'b1, 1'b1,
        '{8'h00, 1'b1, 1'b0, 1'b0, lpf_pkg::ST_BYTE_TAKEN}},
      '{lpf_pkg::MODE_READ, 8'h00, 1'b0, 1'b1,
        '{8'hFF, 1'b1, 1'b0, 1'b0, lpf_pkg::ST_BYTE_TAKEN}},
      '{lpf_pkg::MODE_READ, 8'h00, 1'b0, 1'b1,
        '{8'hAA, 1'b1, 1'b0, 1'b0, lpf_pkg::ST_BYTE_TAKEN}},
      '{lpf_pkg::MODE_READ, 8'h00, 1'b0, 1'b1,
        '{8'h55, 1'b1, 1'b0, 1'b1, lpf_pkg::ST_BYTE_TAKEN}},
      '{lpf_pkg::MODE_READ, 8'h00, 1'b0, 1'b0, R_NONE},
      '{lpf_pkg::MODE_READ, 8'h00, 1'b0, 1'b0, R_NONE},
      '{lpf_pkg::MODE_READ, 8'h00, 1'b0, 1'b0, R_NONE},
      '{lpf_pkg::MODE_READ, 8'h00, 1'b0, 1'b0, R_NONE},
      '{lpf_pkg::MODE_READ, 8'h00, 1'b0, 1'b0, R_NONE},
      '{lpf_pkg::MODE_READ, 8'h00, 1'b0, 1'b0, R_NONE},
      '{lpf_pkg::MODE_READ, 8'h00, 1'b0, 1'b1, R_NONE}
    };
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].m, directed_rows[i].b, directed_rows[i].l,
                directed_rows[i].typed, directed_rows[i].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: cfg = 5'd1;
        1: cfg = 5'd16;
        2: cfg = 5'd0;
        3: cfg = 5'd31;
        default: cfg = ($urandom_range(0, 1) != 0) ? 5'($urandom_range(1, QUEUE_DEPTH))
                                                   : 5'($urandom);
      endcase
      wait_drained();
      @(negedge clk);
      cfg_write_en <= 1'b1;
      cfg_write_data <= cfg;
      @(negedge clk);
      cfg_write_en <= 1'b0;
      slot_limit_cfg = cfg;

      no_gaps = (ph % 3 == 2);
      push_pct = $urandom_range(30, 70);
      phase_start = items_sent;
      // One packet long enough to saturate the push byte counter.
      if (ph == 1) push_packet(3, 270);
      while (items_sent - phase_start < ITEMS_PER_PHASE) begin
        r = $urandom_range(0, 99);
        if (r < push_pct) begin
          kind = $urandom_range(0, 999);
          if (kind < 820) begin
            r = $urandom_range(0, 99);
            if (r < 70) sz = $urandom_range(0, 8);
            else if (r < 95) sz = $urandom_range(9, MAX_DATA - 1);
            else sz = MAX_DATA;
            n = HEADER_LEN + sz;
            // Trailing bytes past the declared size, sometimes past the slot.
            if ($urandom_range(0, 9) == 0) n += $urandom_range(1, 10);
          end else if (kind < 900) begin
            sz = $urandom_range(MAX_DATA + 1, 255);
            n = $urandom_range(HEADER_LEN, HEADER_LEN + 8);
          end else if (kind < 997) begin
            sz = $urandom_range(0, MAX_DATA);
            n = $urandom_range(1, HEADER_LEN + sz - 1);
          end else begin
            sz = $urandom_range(0, MAX_DATA);
            n = $urandom_range(256, 300);
          end
          push_packet(sz, n);
        end else if (r < 96) begin
          repeat ($urandom_range(1, 12)) begin
            send_item(lpf_pkg::MODE_READ, 8'($urandom), 1'($urandom), 1'b0, R_NONE);
          end
        end else if (r < 98) begin
          send_item(1'($urandom), 8'($urandom), 1'($urandom), 1'b0, R_NONE);
        end else begin
          wait_drained();
        end
      end
    end

    wait_drained();
    repeat (8) @(negedge clk);
    $display("Checked %0d replies from %0d transactions across %0d slot-limit settings.",
             n_checked, items_sent, PHASES);
    $display("Packets queued %0d, dropped full %0d, dropped size %0d; %0d bytes read out.",
             n_queued, n_drop_full, n_drop_size, n_serialized);
    if (err_count == 0) begin
      $display("** length_prefixed_packet_fifo_framer_top: PASSED **");
    end else begin
      $display("** length_prefixed_packet_fifo_framer_top: FAILED **");
    end
    $finish;
  end

endmodule
